>>> sv/sgfa_pkg.sv
package sgfa_pkg;

    localparam int W_CFG      = 32;
    localparam int W_POS_IN   = 32;
    localparam int W_SUM      = 64;
    localparam int W_WIDE     = 128;
    localparam int W_ROOT     = 64;
    localparam int W_REM      = W_ROOT + 2;
    localparam int GM_FRAC    = 16;
    localparam int SQRT_STEPS = W_ROOT;
    localparam int DIV_STEPS  = W_WIDE;
    localparam int W_CNT      = $clog2(DIV_STEPS);
    localparam int N_AXES     = 3;

    localparam logic [W_CFG-1:0] RST_GM_STAR       = 32'd65536;
    localparam logic [W_CFG-1:0] RST_GM_HEAVY      = 32'd655360000;
    localparam logic [W_CFG-1:0] RST_SOFT_SQ_STAR  = 32'd1678;
    localparam logic [W_CFG-1:0] RST_SOFT_SQ_HEAVY = 32'd167772;

    localparam logic [W_SUM-1:0] SUM_MAX = {1'b0, {(W_SUM-1){1'b1}}};
    localparam logic [W_SUM-1:0] SUM_MIN = {1'b1, {(W_SUM-1){1'b0}}};

    typedef enum logic [1:0] {
        CFG_GM_STAR       = 2'd0,
        CFG_GM_HEAVY      = 2'd1,
        CFG_SOFT_SQ_STAR  = 2'd2,
        CFG_SOFT_SQ_HEAVY = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ_INIT,
        OP_MUL_LOAD,
        OP_GM_INIT,
        OP_MUL_STEP,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_ADD,
        OP_ADD_CLIP,
        OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_SQ,
        S_SQLD,
        S_SQI,
        S_SQRT,
        S_GM,
        S_GMUL,
        S_CHK,
        S_DIV,
        S_ADD,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_op   op;
        t_axis axis;
    } t_cmd;

    typedef struct packed {
        logic mag_zero;
        logic div_clip;
        logic last;
        logic out_free;
        logic in_valid;
    } t_sts;

endpackage

>>> sv/sgfa_in_if.sv
interface sgfa_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [sgfa_pkg::W_POS_IN-1:0] target_x;
    logic signed [sgfa_pkg::W_POS_IN-1:0] target_y;
    logic signed [sgfa_pkg::W_POS_IN-1:0] target_z;
    logic signed [sgfa_pkg::W_POS_IN-1:0] source_x;
    logic signed [sgfa_pkg::W_POS_IN-1:0] source_y;
    logic signed [sgfa_pkg::W_POS_IN-1:0] source_z;
    logic                              target_heavy;
    logic                              source_heavy;
    logic                              last_source;

    modport source (
        output valid, target_x, target_y, target_z, source_x, source_y, source_z,
               target_heavy, source_heavy, last_source,
        input  ready
    );
    modport sink (
        input  valid, target_x, target_y, target_z, source_x, source_y, source_z,
               target_heavy, source_heavy, last_source,
        output ready
    );
endinterface

>>> sv/sgfa_out_if.sv
interface sgfa_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [sgfa_pkg::W_SUM-1:0]  accel_x;
    logic signed [sgfa_pkg::W_SUM-1:0]  accel_y;
    logic signed [sgfa_pkg::W_SUM-1:0]  accel_z;
    logic                               saturated;

    modport source (
        output valid, accel_x, accel_y, accel_z, saturated,
        input  ready
    );
    modport sink (
        input  valid, accel_x, accel_y, accel_z, saturated,
        output ready
    );
endinterface

>>> sv/sgfa_ctrl.sv
module sgfa_ctrl #(
    parameter int POS_BITS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sgfa_pkg::t_sts  i_sts,
    output sgfa_pkg::t_cmd  o_cmd,
    output logic            o_in_ready
);
    localparam int MUL_STEPS = POS_BITS + 1;
    localparam logic [sgfa_pkg::W_CNT-1:0] MUL_LAST  = sgfa_pkg::W_CNT'(MUL_STEPS - 1);
    localparam logic [sgfa_pkg::W_CNT-1:0] SQRT_LAST =
        sgfa_pkg::W_CNT'(sgfa_pkg::SQRT_STEPS - 1);
    localparam logic [sgfa_pkg::W_CNT-1:0] DIV_LAST  =
        sgfa_pkg::W_CNT'(sgfa_pkg::DIV_STEPS - 1);

    sgfa_pkg::t_state          r_state, n_state;
    logic [sgfa_pkg::W_CNT-1:0] r_cnt, n_cnt;
    sgfa_pkg::t_axis           r_axis, n_axis;
    logic [1:0]                r_k, n_k;
    logic                      w_axis_last;

    assign w_axis_last = (r_axis == sgfa_pkg::AXIS_Z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sgfa_pkg::S_IDLE;
            r_cnt   <= '0;
            r_axis  <= sgfa_pkg::AXIS_X;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_axis  <= n_axis;
            r_k     <= n_k;
        end
    end

    // next state and counters
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_axis  = r_axis;
        n_k     = r_k;
        unique case (r_state)
            sgfa_pkg::S_IDLE: begin
                if (i_sts.in_valid) begin
                    n_state = sgfa_pkg::S_START;
                end
            end
            sgfa_pkg::S_START: begin
                n_cnt  = '0;
                n_axis = sgfa_pkg::AXIS_X;
                n_state = i_sts.mag_zero ? sgfa_pkg::S_EMIT : sgfa_pkg::S_SQ;
            end
            sgfa_pkg::S_SQ: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == MUL_LAST) begin
                    n_cnt = '0;
                    if (w_axis_last) begin
                        n_state = sgfa_pkg::S_SQI;
                    end else begin
                        n_axis  = sgfa_pkg::t_axis'(r_axis + 2'd1);
                        n_state = sgfa_pkg::S_SQLD;
                    end
                end
            end
            sgfa_pkg::S_SQLD: begin
                n_state = sgfa_pkg::S_SQ;
            end
            sgfa_pkg::S_SQI: begin
                n_cnt   = '0;
                n_state = sgfa_pkg::S_SQRT;
            end
            sgfa_pkg::S_SQRT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == SQRT_LAST) begin
                    n_cnt   = '0;
                    n_axis  = sgfa_pkg::AXIS_X;
                    n_state = sgfa_pkg::S_GM;
                end
            end
            sgfa_pkg::S_GM: begin
                n_cnt   = '0;
                n_k     = '0;
                n_state = sgfa_pkg::S_GMUL;
            end
            sgfa_pkg::S_GMUL: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == MUL_LAST) begin
                    n_cnt   = '0;
                    n_state = sgfa_pkg::S_CHK;
                end
            end
            sgfa_pkg::S_CHK: begin
                n_cnt = '0;
                if (i_sts.div_clip) begin
                    if (w_axis_last) begin
                        n_state = sgfa_pkg::S_EMIT;
                    end else begin
                        n_axis  = sgfa_pkg::t_axis'(r_axis + 2'd1);
                        n_state = sgfa_pkg::S_GM;
                    end
                end else begin
                    n_state = sgfa_pkg::S_DIV;
                end
            end
            sgfa_pkg::S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_cnt = '0;
                    if (r_k == 2'd2) begin
                        n_state = sgfa_pkg::S_ADD;
                    end else begin
                        n_k     = r_k + 2'd1;
                        n_state = sgfa_pkg::S_CHK;
                    end
                end
            end
            sgfa_pkg::S_ADD: begin
                if (w_axis_last) begin
                    n_state = sgfa_pkg::S_EMIT;
                end else begin
                    n_axis  = sgfa_pkg::t_axis'(r_axis + 2'd1);
                    n_state = sgfa_pkg::S_GM;
                end
            end
            sgfa_pkg::S_EMIT: begin
                if (!i_sts.last || i_sts.out_free) begin
                    n_state = sgfa_pkg::S_IDLE;
                end
            end
            default: n_state = sgfa_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd.op   = sgfa_pkg::OP_NONE;
        o_cmd.axis = r_axis;
        o_in_ready = 1'b0;
        unique case (r_state)
            sgfa_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    o_cmd.op = sgfa_pkg::OP_LOAD;
                end
            end
            sgfa_pkg::S_START: begin
                if (!i_sts.mag_zero) begin
                    o_cmd.op   = sgfa_pkg::OP_SQ_INIT;
                    o_cmd.axis = sgfa_pkg::AXIS_X;
                end
            end
            sgfa_pkg::S_SQ:   o_cmd.op = sgfa_pkg::OP_MUL_STEP;
            sgfa_pkg::S_SQLD: o_cmd.op = sgfa_pkg::OP_MUL_LOAD;
            sgfa_pkg::S_SQI:  o_cmd.op = sgfa_pkg::OP_SQRT_INIT;
            sgfa_pkg::S_SQRT: o_cmd.op = sgfa_pkg::OP_SQRT_STEP;
            sgfa_pkg::S_GM:   o_cmd.op = sgfa_pkg::OP_GM_INIT;
            sgfa_pkg::S_GMUL: o_cmd.op = sgfa_pkg::OP_MUL_STEP;
            sgfa_pkg::S_CHK: begin
                o_cmd.op = i_sts.div_clip ? sgfa_pkg::OP_ADD_CLIP : sgfa_pkg::OP_DIV_INIT;
            end
            sgfa_pkg::S_DIV:  o_cmd.op = sgfa_pkg::OP_DIV_STEP;
            sgfa_pkg::S_ADD:  o_cmd.op = sgfa_pkg::OP_ADD;
            sgfa_pkg::S_EMIT: begin
                if (i_sts.last && i_sts.out_free) begin
                    o_cmd.op = sgfa_pkg::OP_EMIT;
                end
            end
            default: o_cmd.op = sgfa_pkg::OP_NONE;
        endcase
    end
endmodule

>>> sv/sgfa_dpath.sv
module sgfa_dpath #(
    parameter int POS_BITS  = 32,
    parameter int FRAC_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_idx,
    input  logic [sgfa_pkg::W_CFG-1:0]       i_cfg_data,
    input  logic [sgfa_pkg::W_POS_IN-1:0]    i_target_x,
    input  logic [sgfa_pkg::W_POS_IN-1:0]    i_target_y,
    input  logic [sgfa_pkg::W_POS_IN-1:0]    i_target_z,
    input  logic [sgfa_pkg::W_POS_IN-1:0]    i_source_x,
    input  logic [sgfa_pkg::W_POS_IN-1:0]    i_source_y,
    input  logic [sgfa_pkg::W_POS_IN-1:0]    i_source_z,
    input  logic                             i_target_heavy,
    input  logic                             i_source_heavy,
    input  logic                             i_last_source,
    input  logic                             i_in_valid,
    input  sgfa_pkg::t_cmd                   i_cmd,
    output sgfa_pkg::t_sts                   o_sts,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [sgfa_pkg::W_SUM-1:0]       o_accel_x,
    output logic [sgfa_pkg::W_SUM-1:0]       o_accel_y,
    output logic [sgfa_pkg::W_SUM-1:0]       o_accel_z,
    output logic                             o_saturated
);
    localparam int W   = sgfa_pkg::W_WIDE;
    localparam int WS  = sgfa_pkg::W_SUM;
    localparam int WR  = sgfa_pkg::W_ROOT;
    localparam logic [WS-1:0] POS_MASK = (64'd1 << POS_BITS) - 64'd1;

    logic [sgfa_pkg::W_CFG-1:0] r_gm_star, r_gm_heavy, r_soft_star, r_soft_heavy;
    logic [WS-1:0]              r_mag [sgfa_pkg::N_AXES];
    logic [sgfa_pkg::N_AXES-1:0] r_sub;
    logic [sgfa_pkg::W_CFG-1:0] r_gm, r_eps;
    logic                       r_last;
    logic [W-1:0]               r_acc, r_ma;
    logic [WS-1:0]              r_mb;
    logic [sgfa_pkg::W_REM-1:0] r_rem;
    logic [WR-1:0]              r_root;
    logic [WS-1:0]              r_sum [sgfa_pkg::N_AXES];
    logic                       r_clip;
    logic                       r_out_valid;
    logic [WS-1:0]              r_out_x, r_out_y, r_out_z;
    logic                       r_out_sat;

    logic [WS-1:0]              w_d [sgfa_pkg::N_AXES];
    logic [sgfa_pkg::W_REM-1:0] w_sq_t, w_sq_trial;
    logic [WR:0]                w_dv_t;
    logic                       w_dv_ge;
    logic                       w_term_clip;
    logic [WS-1:0]              w_term, w_addend, w_s, w_sat;
    logic                       w_neg, w_ovf;
    logic [WS-1:0]              w_acc_cur;
    logic                       w_out_free;

    function automatic logic [WS-1:0] f_ext(input logic [sgfa_pkg::W_POS_IN-1:0] v);
        logic [WS-1:0] e;
        e = {{(WS-sgfa_pkg::W_POS_IN){1'b0}}, v} & POS_MASK;
        if (e[POS_BITS-1]) begin
            e = e | ~POS_MASK;
        end
        return e;
    endfunction

    assign w_d[0] = f_ext(i_target_x) - f_ext(i_source_x);
    assign w_d[1] = f_ext(i_target_y) - f_ext(i_source_y);
    assign w_d[2] = f_ext(i_target_z) - f_ext(i_source_z);

    // square root digit
    assign w_sq_t     = {r_rem[sgfa_pkg::W_REM-3:0], r_acc[W-1 -: 2]};
    assign w_sq_trial = {r_root, 2'b01};

    // division digit
    assign w_dv_t  = {r_rem[WR-1:0], r_acc[W-1]};
    assign w_dv_ge = (w_dv_t >= {1'b0, r_root});

    // term scaling and saturating add
    assign w_term_clip = (r_acc[W-1:WS-1+sgfa_pkg::GM_FRAC] != '0);
    assign w_term = (i_cmd.op == sgfa_pkg::OP_ADD_CLIP || w_term_clip) ? sgfa_pkg::SUM_MAX
                  : {1'b0, r_acc[WS-2+sgfa_pkg::GM_FRAC:sgfa_pkg::GM_FRAC]};
    assign w_neg     = r_sub[i_cmd.axis];
    assign w_acc_cur = r_sum[i_cmd.axis];
    assign w_addend  = w_neg ? (WS'(0) - w_term) : w_term;
    assign w_s       = w_acc_cur + w_addend;
    always_comb begin
        w_ovf = 1'b0;
        w_sat = w_s;
        if (!w_neg && !w_acc_cur[WS-1] && w_s[WS-1]) begin
            w_ovf = 1'b1;
            w_sat = sgfa_pkg::SUM_MAX;
        end else if (w_neg && w_acc_cur[WS-1] && !w_s[WS-1]) begin
            w_ovf = 1'b1;
            w_sat = sgfa_pkg::SUM_MIN;
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    assign o_sts.mag_zero = ((r_mag[0] | r_mag[1] | r_mag[2]) == '0);
    assign o_sts.div_clip = ((r_acc >> (W - FRAC_BITS)) != '0);
    assign o_sts.last     = r_last;
    assign o_sts.out_free = w_out_free;
    assign o_sts.in_valid = i_in_valid;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gm_star    <= sgfa_pkg::RST_GM_STAR;
            r_gm_heavy   <= sgfa_pkg::RST_GM_HEAVY;
            r_soft_star  <= sgfa_pkg::RST_SOFT_SQ_STAR;
            r_soft_heavy <= sgfa_pkg::RST_SOFT_SQ_HEAVY;
        end else if (i_cfg_we) begin
            unique case (sgfa_pkg::t_cfg_idx'(i_cfg_idx))
                sgfa_pkg::CFG_GM_STAR:       r_gm_star    <= i_cfg_data;
                sgfa_pkg::CFG_GM_HEAVY:      r_gm_heavy   <= i_cfg_data;
                sgfa_pkg::CFG_SOFT_SQ_STAR:  r_soft_star  <= i_cfg_data;
                sgfa_pkg::CFG_SOFT_SQ_HEAVY: r_soft_heavy <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // arithmetic registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            sgfa_pkg::OP_LOAD: begin
                for (int a = 0; a < sgfa_pkg::N_AXES; a++) begin
                    r_mag[a] <= w_d[a][WS-1] ? (WS'(0) - w_d[a]) : w_d[a];
                    r_sub[a] <= !w_d[a][WS-1];
                end
                r_gm   <= i_source_heavy ? r_gm_heavy : r_gm_star;
                r_eps  <= (i_target_heavy || i_source_heavy) ? r_soft_heavy : r_soft_star;
                r_last <= i_last_source;
            end
            sgfa_pkg::OP_SQ_INIT: begin
                r_acc <= {{(W-sgfa_pkg::W_CFG){1'b0}}, r_eps} << FRAC_BITS;
                r_ma  <= {{(W-WS){1'b0}}, r_mag[0]};
                r_mb  <= r_mag[0];
            end
            sgfa_pkg::OP_MUL_LOAD: begin
                r_ma <= {{(W-WS){1'b0}}, r_mag[i_cmd.axis]};
                r_mb <= r_mag[i_cmd.axis];
            end
            sgfa_pkg::OP_GM_INIT: begin
                r_acc <= '0;
                r_ma  <= {{(W-sgfa_pkg::W_CFG){1'b0}}, r_gm};
                r_mb  <= r_mag[i_cmd.axis];
            end
            sgfa_pkg::OP_MUL_STEP: begin
                if (r_mb[0]) begin
                    r_acc <= r_acc + r_ma;
                end
                r_ma <= r_ma << 1;
                r_mb <= r_mb >> 1;
            end
            sgfa_pkg::OP_SQRT_INIT: begin
                r_rem  <= '0;
                r_root <= '0;
            end
            sgfa_pkg::OP_SQRT_STEP: begin
                r_acc <= r_acc << 2;
                if (w_sq_t >= w_sq_trial) begin
                    r_rem  <= w_sq_t - w_sq_trial;
                    r_root <= {r_root[WR-2:0], 1'b1};
                end else begin
                    r_rem  <= w_sq_t;
                    r_root <= {r_root[WR-2:0], 1'b0};
                end
            end
            sgfa_pkg::OP_DIV_INIT: begin
                r_acc <= r_acc << FRAC_BITS;
                r_rem <= '0;
            end
            sgfa_pkg::OP_DIV_STEP: begin
                r_acc <= {r_acc[W-2:0], w_dv_ge};
                r_rem <= sgfa_pkg::W_REM'(w_dv_ge ? (w_dv_t - {1'b0, r_root}) : w_dv_t);
            end
            default: ;
        endcase
    end

    // sums and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < sgfa_pkg::N_AXES; a++) begin
                r_sum[a] <= '0;
            end
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            priority case (i_cmd.op)
                sgfa_pkg::OP_ADD, sgfa_pkg::OP_ADD_CLIP: begin
                    r_sum[i_cmd.axis] <= w_sat;
                    if (w_ovf || w_term_clip || i_cmd.op == sgfa_pkg::OP_ADD_CLIP) begin
                        r_clip <= 1'b1;
                    end
                end
                sgfa_pkg::OP_EMIT: begin
                    for (int a = 0; a < sgfa_pkg::N_AXES; a++) begin
                        r_sum[a] <= '0;
                    end
                    r_clip      <= 1'b0;
                    r_out_valid <= 1'b1;
                end
                default: ;
            endcase
            if (i_cmd.op != sgfa_pkg::OP_EMIT && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == sgfa_pkg::OP_EMIT) begin
            r_out_x   <= r_sum[0];
            r_out_y   <= r_sum[1];
            r_out_z   <= r_sum[2];
            r_out_sat <= r_clip;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_accel_x   = r_out_x;
    assign o_accel_y   = r_out_y;
    assign o_accel_z   = r_out_z;
    assign o_saturated = r_out_sat;
endmodule

>>> sv/softened_gravity_force_accumulator_unit.sv
// Softened direct-summation gravity accumulator. Each request carries one target and one
// source position (signed, FRAC_BITS fraction bits in the low POS_BITS bits) and adds
// -GM*d/r^3 to three saturating 64-bit sums; on last_source the sums and a clip flag leave
// through the output register and are cleared. One request at a time goes through a single
// shift-add multiplier, a one-bit-per-cycle square root and a one-bit-per-cycle divider:
// accepting the request and forming |d|^2, then the root, then per axis the GM product, up
// to three divisions by the root (a value that would overflow the next division ends them
// with a clipped term) and the add, and last the result; a self pair goes straight to the
// result. A pending result does not hold up the next request unless that request is also a
// last source.
module softened_gravity_force_accumulator_unit #(
    parameter int POS_BITS  = 32,
    parameter int FRAC_BITS = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [sgfa_pkg::W_CFG-1:0]  i_cfg_data,
    sgfa_in_if.sink                     i_in,
    sgfa_out_if.source                  o_out
);
    sgfa_pkg::t_cmd w_cmd;
    sgfa_pkg::t_sts w_sts;
    logic           w_in_ready;

    assign i_in.ready = w_in_ready;

    sgfa_ctrl #(
        .POS_BITS (POS_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_ready (w_in_ready)
    );

    sgfa_dpath #(
        .POS_BITS  (POS_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_target_x     (i_in.target_x),
        .i_target_y     (i_in.target_y),
        .i_target_z     (i_in.target_z),
        .i_source_x     (i_in.source_x),
        .i_source_y     (i_in.source_y),
        .i_source_z     (i_in.source_z),
        .i_target_heavy (i_in.target_heavy),
        .i_source_heavy (i_in.source_heavy),
        .i_last_source  (i_in.last_source),
        .i_in_valid     (i_in.valid),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_accel_x      (o_out.accel_x),
        .o_accel_y      (o_out.accel_y),
        .o_accel_z      (o_out.accel_z),
        .o_saturated    (o_out.saturated)
    );
endmodule
